>>> sv/hcd_pkg.sv
// Shared constants, types and state codes of the chunked body decoder.
package hcd_pkg;

    localparam int LEN_BITS    = 32;
    localparam int COUNT_BITS  = 32;
    localparam int BYTE_BITS   = 8;
    localparam int DIGIT_BITS  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_BITS-1:0]  CR_BYTE    = 8'h0D;
    localparam logic [BYTE_BITS-1:0]  TAB_BYTE   = 8'h09;
    localparam logic [BYTE_BITS-1:0]  SPACE_BYTE = 8'h20;
    localparam logic [BYTE_BITS-1:0]  PLUS_BYTE  = 8'h2B;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [LEN_BITS-1:0]   LEN_MAX    = '1;

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_LF     = 3'd3,
        PH_EXT    = 3'd4,
        PH_DATA   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  data;
        logic                  last;
        logic                  is_digit;
        logic [DIGIT_BITS-1:0] digit;
        logic                  is_space;
        logic                  is_plus;
        logic                  is_cr;
    } t_item;

endpackage

>>> sv/hcd_if.sv
// Valid/ready channel interfaces for raw input bytes and decoded results.
interface hcd_in_if;
    import hcd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] in_byte;
    logic                 last_byte;

    modport source (output valid, in_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface hcd_out_if;
    import hcd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BYTE_BITS-1:0]  out_byte;
    logic                  has_data;
    logic                  is_end;
    logic                  status;
    logic [COUNT_BITS-1:0] total_length;

    modport source (output valid, out_byte, has_data, is_end, status, total_length,
                    input ready);
    modport sink   (input valid, out_byte, has_data, is_end, status, total_length,
                    output ready);
endinterface

>>> sv/hcd_front.sv
// Front end: accept raw bytes and classify them for the decode engine.
module hcd_front (
    hcd_in_if.sink           i_in,
    input  logic             i_full,
    output logic             o_push,
    output hcd_pkg::t_item   o_item
);
    import hcd_pkg::*;

    logic [BYTE_BITS-1:0] b;

    assign b         = i_in.in_byte;
    assign i_in.ready = !i_full;
    assign o_push    = i_in.valid && !i_full;

    always_comb begin
        o_item          = '0;
        o_item.data     = b;
        o_item.last     = i_in.last_byte;
        o_item.is_space = (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
        o_item.is_plus  = (b == PLUS_BYTE);
        o_item.is_cr    = (b == CR_BYTE);
        unique case (b) inside
            [8'h30:8'h39]: begin
                o_item.is_digit = 1'b1;
                o_item.digit    = b[DIGIT_BITS-1:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]: begin
                o_item.is_digit = 1'b1;
                o_item.digit    = DIGIT_BITS'(b[DIGIT_BITS-1:0] + 4'd9);
            end
            default: begin
                o_item.is_digit = 1'b0;
                o_item.digit    = '0;
            end
        endcase
    end

endmodule

>>> sv/hcd_queue.sv
// Short register queue between the classifier and the decode engine.
module hcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hcd_pkg::t_item o_item
);
    import hcd_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count,  n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : QPTR_BITS'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : QPTR_BITS'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = QCNT_BITS'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = QCNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> sv/hcd_back.sv
// Decode engine: chunk header state machine, counters and output register.
module hcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hcd_pkg::t_item i_item,
    output logic           o_pop,
    hcd_out_if.source      o_out
);
    import hcd_pkg::*;

    t_phase                r_phase,      n_phase;
    logic [LEN_BITS-1:0]   r_length_acc, n_length_acc;
    logic [LEN_BITS-1:0]   r_bytes_left, n_bytes_left;
    logic [COUNT_BITS-1:0] r_out_count,  n_out_count;

    logic                  r_out_valid,  n_out_valid;
    logic [BYTE_BITS-1:0]  r_out_byte,   n_out_byte;
    logic                  r_has_data,   n_has_data;
    logic                  r_is_end,     n_is_end;
    logic                  r_status,     n_status;
    logic [COUNT_BITS-1:0] r_total,      n_total;

    logic                  has;
    logic                  short_err;
    logic                  load;
    logic [LEN_BITS-1:0]   acc_shift;
    logic                  acc_sat;

    assign o_pop              = i_valid && (!r_out_valid || o_out.ready);
    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.has_data     = r_has_data;
    assign o_out.is_end       = r_is_end;
    assign o_out.status       = r_status;
    assign o_out.total_length = r_total;

    assign acc_sat   = (r_length_acc[LEN_BITS-1 -: DIGIT_BITS] != '0);
    assign acc_shift = {r_length_acc[LEN_BITS-DIGIT_BITS-1:0], i_item.digit};

    always_comb begin
        n_phase      = r_phase;
        n_length_acc = r_length_acc;
        n_bytes_left = r_bytes_left;
        n_out_count  = r_out_count;
        has          = 1'b0;

        if (o_pop) begin
            unique case (r_phase)
                PH_WS: begin
                    if (i_item.is_space) begin
                        n_phase = PH_WS;
                    end else if (i_item.is_plus) begin
                        n_phase = PH_SIGN;
                    end else if (i_item.is_digit) begin
                        n_length_acc = LEN_BITS'(i_item.digit);
                        n_phase      = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGN: begin
                    if (i_item.is_digit) begin
                        n_length_acc = LEN_BITS'(i_item.digit);
                        n_phase      = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (i_item.is_digit) begin
                        n_length_acc = acc_sat ? LEN_MAX : acc_shift;
                    end else if (r_length_acc == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = i_item.is_cr ? PH_LF : PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (i_item.is_cr) begin
                        n_phase = PH_LF;
                    end
                end
                PH_LF: begin
                    n_bytes_left = r_length_acc;
                    n_phase      = PH_DATA;
                end
                PH_DATA: begin
                    has          = 1'b1;
                    n_bytes_left = LEN_BITS'(r_bytes_left - 1'b1);
                    if (r_out_count != COUNT_MAX) begin
                        n_out_count = COUNT_BITS'(r_out_count + 1'b1);
                    end
                    if (r_bytes_left == LEN_BITS'(1)) begin
                        n_length_acc = '0;
                        n_phase      = PH_WS;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        short_err = ((n_phase == PH_DIGITS) && (n_length_acc != '0)) ||
                    (n_phase == PH_LF) || (n_phase == PH_EXT) || (n_phase == PH_DATA);

        load        = o_pop && (has || i_item.last);
        n_out_valid = load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
        n_out_byte  = has ? i_item.data : '0;
        n_has_data  = has;
        n_is_end    = i_item.last;
        n_status    = i_item.last && short_err;
        n_total     = i_item.last ? n_out_count : '0;

        if (o_pop && i_item.last) begin
            n_phase      = PH_WS;
            n_length_acc = '0;
            n_bytes_left = '0;
            n_out_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WS;
            r_length_acc <= '0;
            r_bytes_left <= '0;
            r_out_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_length_acc <= n_length_acc;
            r_bytes_left <= n_bytes_left;
            r_out_count  <= n_out_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= n_out_byte;
            r_has_data <= n_has_data;
            r_is_end   <= n_is_end;
            r_status   <= n_status;
            r_total    <= n_total;
        end
    end

endmodule

>>> sv/http_chunked_decoder.sv
// HTTP chunked body decoder, top level.
//
// i_in carries one raw body byte per transfer, with last_byte marking the
// final byte. o_out carries decoded results: a payload byte (has_data), an
// end marker (is_end with status and total_length), or both in one transfer.
// Header bytes, extensions and the CR/LF framing produce no transfer.
//
// Throughput is one input byte per cycle unless the receiver stalls, set by
// the decode state machine, which retires one queued byte per cycle. An input
// byte is registered in the classifier queue, then passes through the decode
// engine into the output register.
//
// When the receiver stalls, the held result stays on o_out and the engine
// stops; up to four further bytes collect in the queue before i_in.ready
// drops. Reset empties the queue and the output register and returns the
// decoder to the start of a header; no clearing pass is needed. After the
// end marker the decoder is back in its reset state for the next body.
module http_chunked_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcd_in_if.sink     i_in,
    hcd_out_if.source  o_out
);
    import hcd_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item push_item;
    t_item head_item;

    hcd_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    hcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    hcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> sv/hcd_checker.sv
// Port-level checks on the decoder result channel, bound to the top level.
module hcd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [hcd_pkg::BYTE_BITS-1:0]  i_out_byte,
    input logic                           i_has_data,
    input logic                           i_is_end,
    input logic                           i_status,
    input logic [hcd_pkg::COUNT_BITS-1:0] i_total_length
);
    import hcd_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
            $stable(i_has_data) && $stable(i_is_end) && $stable(i_status) &&
            $stable(i_total_length))
        else $error("stalled result changed");

    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_has_data || i_is_end)
        else $error("result carries neither data nor end marker");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_end |-> !i_status && (i_total_length == '0))
        else $error("status or total set without end marker");

    a_data_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_data |-> (i_out_byte == '0))
        else $error("payload byte set without data flag");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_has_data     (o_out.has_data),
    .i_is_end       (o_out.is_end),
    .i_status       (o_out.status),
    .i_total_length (o_out.total_length)
);

>>> test/http_chunked_decoder_tb.sv
// Self-checking testbench for the chunked body decoder: paced random stimulus, scoreboard check.
module http_chunked_decoder_tb;
    import hcd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int TARGET_ITEMS = 550;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HEX_RADIX    = 16;
    localparam int NO_DIGIT     = 16;
    localparam int LONG_CHUNK   = 40;

    localparam logic [BYTE_BITS-1:0] LF_BYTE   = 8'h0A;
    localparam logic [BYTE_BITS-1:0] NUL_BYTE  = 8'h00;
    localparam logic [BYTE_BITS-1:0] SEMI_BYTE = 8'h3B;
    localparam logic [BYTE_BITS-1:0] DASH_BYTE = 8'h2D;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  out_byte;
        logic                  has_data;
        logic                  is_end;
        logic                  status;
        logic [COUNT_BITS-1:0] total_length;
    } t_decoded;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    class chunk_scoreboard;
        t_phase                ph;
        logic [LEN_BITS-1:0]   len_acc;
        logic [LEN_BITS-1:0]   left;
        logic [COUNT_BITS-1:0] count;
        logic                  short_err;
        t_decoded              expected_q[$];
        int                    errors;
        int                    seen;

        function new();
            clear_state();
            errors = 0;
            seen   = 0;
        endfunction

        function void clear_state();
            ph        = PH_WS;
            len_acc   = '0;
            left      = '0;
            count     = '0;
            short_err = 1'b0;
        endfunction

        function int unsigned hex_val(logic [BYTE_BITS-1:0] b);
            if (b >= "0" && b <= "9") return b - "0";
            if (b >= "a" && b <= "f") return b - "a" + 10;
            if (b >= "A" && b <= "F") return b - "A" + 10;
            return NO_DIGIT;
        endfunction

        function logic is_ws(logic [BYTE_BITS-1:0] b);
            return b == SPACE_BYTE || (b >= TAB_BYTE && b <= CR_BYTE);
        endfunction

        function logic [LEN_BITS-1:0] push_digit(logic [LEN_BITS-1:0] acc, int unsigned d);
            logic [LEN_BITS-1:0] dv;
            logic [LEN_BITS-1:0] radix;
            dv    = LEN_BITS'(d);
            radix = LEN_BITS'(HEX_RADIX);
            if (acc > (LEN_MAX - dv) / radix) return LEN_MAX;
            return acc * radix + dv;
        endfunction

        function void note_input(logic [BYTE_BITS-1:0] b, logic last);
            int unsigned d;
            logic        has;
            t_decoded    e;
            d   = hex_val(b);
            has = 1'b0;
            case (ph)
                PH_WS: begin
                    if (b == PLUS_BYTE) begin
                        ph = PH_SIGN;
                    end else if (d < NO_DIGIT) begin
                        len_acc = push_digit('0, d);
                        ph = PH_DIGITS;
                    end else if (!is_ws(b)) begin
                        ph = PH_DONE;
                    end
                end
                PH_SIGN: begin
                    if (d < NO_DIGIT) begin
                        len_acc = push_digit('0, d);
                        ph = PH_DIGITS;
                    end else begin
                        ph = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (d < NO_DIGIT) begin
                        len_acc = push_digit(len_acc, d);
                    end else if (len_acc == '0) begin
                        ph = PH_DONE;
                    end else begin
                        ph = (b == CR_BYTE) ? PH_LF : PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (b == CR_BYTE) ph = PH_LF;
                end
                PH_LF: begin
                    left = len_acc;
                    ph = PH_DATA;
                end
                PH_DATA: begin
                    has = 1'b1;
                    if (count != COUNT_MAX) count = count + 1'b1;
                    left = left - 1'b1;
                    if (left == '0) begin
                        len_acc = '0;
                        ph = PH_WS;
                    end
                end
                default: ph = PH_DONE;
            endcase
            short_err = (ph == PH_DIGITS && len_acc != '0) || ph == PH_LF ||
                        ph == PH_EXT || ph == PH_DATA;
            if (has || last) begin
                e.out_byte     = has ? b : '0;
                e.has_data     = has;
                e.is_end       = last;
                e.status       = last && short_err;
                e.total_length = last ? count : '0;
                expected_q.push_back(e);
            end
            if (last) clear_state();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check(t_decoded got);
            t_decoded e;
            seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d: none expected (byte %h has %b end %b)",
                                 seen, got.out_byte, got.has_data, got.is_end));
                return;
            end
            e = expected_q.pop_front();
            if (got.out_byte !== e.out_byte)
                report($sformatf("result %0d: out_byte %h, want %h", seen, got.out_byte,
                                 e.out_byte));
            if (got.has_data !== e.has_data)
                report($sformatf("result %0d: has_data %b, want %b", seen, got.has_data,
                                 e.has_data));
            if (got.is_end !== e.is_end)
                report($sformatf("result %0d: is_end %b, want %b", seen, got.is_end,
                                 e.is_end));
            if (got.status !== e.status)
                report($sformatf("result %0d: status %b, want %b", seen, got.status,
                                 e.status));
            if (got.total_length !== e.total_length)
                report($sformatf("result %0d: total_length %0d, want %0d", seen,
                                 got.total_length, e.total_length));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    hcd_in_if  in_ch();
    hcd_out_if out_ch();

    http_chunked_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    chunk_scoreboard sb = new();

    logic [BYTE_BITS-1:0] body[$];
    int items_sent = 0;
    int burst_left = 0;
    int hold_req   = 0;
    logic no_gaps  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        sb.report($sformatf("timeout after %0d cycles, %0d results pending", cycles,
                            sb.pending()));
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       hold_seen;
        int       tick;
        logic     rdy;
        t_decoded got;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.out_byte     = out_ch.out_byte;
                got.has_data     = out_ch.has_data;
                got.is_end       = out_ch.is_end;
                got.status       = out_ch.status;
                got.total_length = out_ch.total_length;
                sb.check(got);
            end
            if (hold_left == 0 && hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(RX_OPEN, RX_SPARSE));
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:     rdy = 1'b1;
                    RX_COIN:     rdy = 1'($urandom_range(0, 1));
                    RX_PERIODIC: rdy = (tick % 4) != 0;
                    default:     rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    task pace();
        int gap;
        if (no_gaps) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= BYTE_BITS'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_item(logic [BYTE_BITS-1:0] b, logic last);
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        sb.note_input(b, last);
        items_sent++;
        pace();
    endtask

    task send_body();
        for (int i = 0; i < body.size(); i++)
            send_item(body[i], i == body.size() - 1);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function logic [BYTE_BITS-1:0] hex_char(int unsigned d);
        if (d < 10) return BYTE_BITS'("0" + d);
        return BYTE_BITS'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
    endfunction

    function void add_chunk(int unsigned len);
        int unsigned digits[$];
        int unsigned v;
        repeat ($urandom_range(0, 2))
            body.push_back($urandom_range(0, 1) ? SPACE_BYTE
                                                : BYTE_BITS'(TAB_BYTE + $urandom_range(0, 4)));
        if ($urandom_range(0, 3) == 0) body.push_back(PLUS_BYTE);
        if ($urandom_range(0, 4) == 0) body.push_back("0");
        v = len;
        while (v != 0) begin
            digits.push_front(v % HEX_RADIX);
            v = v / HEX_RADIX;
        end
        foreach (digits[i]) body.push_back(hex_char(digits[i]));
        if ($urandom_range(0, 4) < 2) begin
            body.push_back(SEMI_BYTE);
            repeat ($urandom_range(0, 4)) begin
                v = $urandom_range(0, 255);
                body.push_back(v == CR_BYTE ? NUL_BYTE : v[BYTE_BITS-1:0]);
            end
        end
        body.push_back(CR_BYTE);
        body.push_back($urandom_range(0, 9) == 0 ? BYTE_BITS'($urandom_range(0, 255))
                                                 : LF_BYTE);
        repeat (len) body.push_back(BYTE_BITS'($urandom_range(0, 255)));
    endfunction

    function void add_terminator();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            body.push_back("0");
            body.push_back(CR_BYTE);
            body.push_back(LF_BYTE);
            body.push_back(CR_BYTE);
            body.push_back(LF_BYTE);
        end else if (r == 8) begin
            body.push_back(DASH_BYTE);
            body.push_back(BYTE_BITS'($urandom_range(0, 255)));
        end
    endfunction

    function void build_body();
        int r;
        int cut;
        body.delete();
        r = $urandom_range(0, 99);
        if (r < 10) begin
            repeat ($urandom_range(1, 8)) body.push_back(BYTE_BITS'($urandom_range(0, 255)));
        end else if (r < 20) begin
            body.push_back(hex_char($urandom_range(1, 15)));
            repeat ($urandom_range(8, 10)) body.push_back(hex_char($urandom_range(0, 15)));
            body.push_back(CR_BYTE);
            body.push_back(LF_BYTE);
            repeat ($urandom_range(1, 6)) body.push_back(BYTE_BITS'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) add_chunk($urandom_range(1, 12));
            add_terminator();
        end
        if (body.size() == 0) body.push_back(BYTE_BITS'($urandom_range(0, 255)));
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, body.size());
            while (body.size() > cut) void'(body.pop_back());
        end
    endfunction

    initial begin
        int bodies;
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= '0;
        in_ch.last_byte <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        body = '{SPACE_BYTE, TAB_BYTE, PLUS_BYTE, "3", SEMI_BYTE, NUL_BYTE, CR_BYTE, LF_BYTE,
                 8'h00, 8'hFF, 8'h80, "0"};
        send_body();
        body = '{PLUS_BYTE, SPACE_BYTE};
        send_body();
        body = '{NUL_BYTE, "x", "1"};
        send_body();
        body = '{"2", CR_BYTE, LF_BYTE, "A"};
        send_body();
        body = '{"F"};
        send_body();
        drain();

        bodies = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (bodies == 4) begin
                body.delete();
                add_chunk(LONG_CHUNK);
                add_terminator();
                no_gaps = 1'b1;
                hold_req++;
            end else begin
                build_body();
            end
            send_body();
            no_gaps = 1'b0;
            if (bodies % 15 == 7) drain();
            bodies++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
